// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the set-associative lookup block.
// Assumes clk and arst_n are visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SACL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sacl assertion failed");
`define SACL_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sacl forbidden condition seen");
`else
`define SACL_ASSERT(lbl, prop)
`define SACL_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/sacl_pkg.sv
`timescale 1ns / 1ps
// Package for the set-associative lookup block: sizes, codes, row and control types.
// No dependencies; imported by every module of the block.
package sacl_pkg;

	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_W       = 64;
	localparam int SET_W        = MAX_SET_BITS;
	localparam int WAY_W        = $clog2(MAX_WAYS);
	localparam int NUM_SETS     = 1 << SET_W;
	localparam int TAG_ADDR_W   = SET_W + WAY_W;
	localparam int NUM_LINES    = 1 << TAG_ADDR_W;
	localparam int RANK_W       = 3;
	localparam int CNT_W        = 32;
	localparam int SETB_W       = 3;
	localparam int OFFB_W       = 6;
	localparam int WAYSCFG_W    = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;
	localparam int SHIFT_W      = OFFB_W + 1;

	localparam logic [RANK_W-1:0]    RANK_MAX  = '1;
	localparam logic [CNT_W-1:0]     CNT_MAX   = '1;
	localparam logic [SETB_W-1:0]    SETB_MAX  = SETB_W'(MAX_SET_BITS);
	localparam logic [WAYSCFG_W-1:0] WAYS_MAX  = WAYSCFG_W'(MAX_WAYS);

	localparam logic [SETB_W-1:0]    RST_SET_BITS = 3'd6;
	localparam logic [OFFB_W-1:0]    RST_OFF_BITS = 6'd6;
	localparam logic [WAYSCFG_W-1:0] RST_WAYS     = 4'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_OFFSET_BITS = 2'd1,
		CFG_WAYS        = 2'd2,
		CFG_POLICY      = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		POL_LRU  = 1'b0,
		POL_PLRU = 1'b1
	} policy_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_LOOK,
		ST_CMP,
		ST_UPDATE
	} state_t;

	// replacement metadata of one set
	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
		logic [MAX_WAYS-1:0]             recent;
	} meta_row_t;

	typedef struct packed {
		logic [WAY_W-1:0] way;   // way being accessed
		logic [WAY_W-1:0] last;  // highest way in use
		policy_t          policy;
		logic             fill;  // miss: mark the way valid
	} repl_ctrl_t;

endpackage

// File: rtl/sacl_tag_store.sv
`timescale 1ns / 1ps
// Tag memory, one entry per line, with registered read and the shared tag comparator.
// Depends on sacl_pkg.
module sacl_tag_store (
	input  logic                                clk,
	input  logic                                rd_en,
	input  logic [sacl_pkg::TAG_ADDR_W-1:0]     rd_addr,
	input  logic [sacl_pkg::ADDR_W-1:0]         cmp_tag,
	output logic                                match,
	input  logic                                wr_en,
	input  logic [sacl_pkg::TAG_ADDR_W-1:0]     wr_addr,
	input  logic [sacl_pkg::ADDR_W-1:0]         wr_tag
);
	import sacl_pkg::*;

	logic [ADDR_W-1:0] mem [NUM_LINES];
	logic [ADDR_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_tag;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign match = (rd_q == cmp_tag);

endmodule

// File: rtl/sacl_meta_store.sv
`timescale 1ns / 1ps
// Per-set replacement metadata memory (valid, age ranks, recent bits).
// Sweeps every row to zero after reset. Depends on sacl_pkg.
module sacl_meta_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [sacl_pkg::SET_W-1:0]      rd_set,
	output sacl_pkg::meta_row_t             rd_row,
	input  logic                            wr_en,
	input  logic [sacl_pkg::SET_W-1:0]      wr_set,
	input  sacl_pkg::meta_row_t             wr_row,
	output logic                            busy
);
	import sacl_pkg::*;

	meta_row_t        mem [NUM_SETS];
	meta_row_t        rd_q;
	logic [SET_W-1:0] clr_idx_q;
	logic             clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_set] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[rd_set];
		end
	end

	assign rd_row = rd_q;
	assign busy   = clr_busy_q;

endmodule

// File: rtl/sacl_repl_update.sv
`timescale 1ns / 1ps
// Next replacement state of one set after an access: LRU rank aging or bit-PLRU.
// Depends on sacl_pkg.
module sacl_repl_update (
	input  sacl_pkg::meta_row_t  row_in,
	input  sacl_pkg::repl_ctrl_t ctrl,
	output sacl_pkg::meta_row_t  row_out
);
	import sacl_pkg::*;

	logic [WAY_W:0]    clear_cnt;
	logic [RANK_W-1:0] old_rank;
	logic [MAX_WAYS-1:0] in_use;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = (WAY_W'(i) <= ctrl.last);
		end
	end

	always_comb begin
		row_out   = row_in;
		old_rank  = row_in.rank[ctrl.way];
		clear_cnt = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (in_use[i] && !row_in.recent[i]) begin
				clear_cnt = clear_cnt + 1'b1;
			end
		end
		if (ctrl.policy == POL_PLRU) begin
			// at most one clear bit left: start a new round
			if (clear_cnt <= (WAY_W+1)'(1)) begin
				for (int i = 0; i < MAX_WAYS; i++) begin
					if (in_use[i]) begin
						row_out.recent[i] = 1'b0;
					end
				end
			end
			row_out.recent[ctrl.way] = 1'b1;
		end else begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (in_use[i] && WAY_W'(i) != ctrl.way && row_in.rank[i] <= old_rank
						&& row_in.rank[i] != RANK_MAX) begin
					row_out.rank[i] = row_in.rank[i] + 1'b1;
				end
			end
			row_out.rank[ctrl.way] = '0;
		end
		if (ctrl.fill) begin
			row_out.valid[ctrl.way] = 1'b1;
		end
	end

endmodule

// File: rtl/set_assoc_cache_lookup_lru_plru.sv
`timescale 1ns / 1ps
// Set-associative cache lookup, top level: config registers, way-scan sequencer, totals.
// Depends on sacl_pkg, sacl_tag_store, sacl_meta_store, sacl_repl_update, assert_macros.svh.
//
// Input channel: in_valid / in_stall with access_address. One address is
// taken while the block is idle; in_stall stays high until it is done.
// Output channel: out_valid / out_stall with was_hit, caused_eviction and
// the saturating hit, miss and eviction totals, one result per address.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// set bits, offset bits, ways in use or policy; cfg_data low bits are used.
// Sequence: the address is latched and split, then each way scanned takes
// one tag memory read and one compare in the single shared comparator,
// then the update. A hit ends the scan; a miss scans every way in use.
// A finished result sits in the output register; if the receiver stalls,
// the update of the next address waits there until the slot frees.
// Reset: the metadata memory is swept to zero, one set per cycle, through
// every set; no address is taken meanwhile, config writes are.
`include "assert_macros.svh"
module set_assoc_cache_lookup_lru_plru (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sacl_pkg::ADDR_W-1:0]         access_address,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                was_hit,
	output logic                                caused_eviction,
	output logic [sacl_pkg::CNT_W-1:0]          hit_total,
	output logic [sacl_pkg::CNT_W-1:0]          miss_total,
	output logic [sacl_pkg::CNT_W-1:0]          eviction_total,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sacl_pkg::*;

	state_t               state_q, state_d;
	logic [SETB_W-1:0]    set_bits_q;
	logic [OFFB_W-1:0]    off_bits_q;
	logic [WAYSCFG_W-1:0] ways_q;
	policy_t              policy_q;

	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    tag_q;
	logic [SET_W-1:0]     set_q;
	logic [WAY_W-1:0]     way_q;
	logic                 hit_q;
	logic [WAY_W-1:0]     hit_way_q;
	logic [WAY_W-1:0]     vict_q;
	logic                 vict_found_q;
	logic                 was_hit_q;
	logic                 evict_q;
	logic                 out_valid_q;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     miss_cnt_q;
	logic [CNT_W-1:0]     evict_cnt_q;

	logic [SETB_W-1:0]    s_eff;
	logic [SHIFT_W-1:0]   tag_shift;
	logic [ADDR_W-1:0]    tag_calc;
	logic [ADDR_W-1:0]    off_shifted;
	logic [SET_W-1:0]     set_mask;
	logic [SET_W-1:0]     set_calc;
	logic [WAY_W-1:0]     last_way;

	meta_row_t            row_rd;
	meta_row_t            row_new;
	repl_ctrl_t           repl_ctrl;
	logic                 meta_busy;
	logic                 tag_match;
	logic                 line_hit;
	logic [WAY_W-1:0]     vict_way;
	logic [WAY_W-1:0]     acc_way;
	logic                 miss_evict;
	logic                 slot_free;
	logic                 commit;
	logic                 look_rd_en;
	logic                 tag_wr_en;

	// address split
	always_comb begin
		s_eff       = (set_bits_q > SETB_MAX) ? SETB_MAX : set_bits_q;
		tag_shift   = {1'b0, off_bits_q} + {{(SHIFT_W-SETB_W){1'b0}}, s_eff};
		tag_calc    = (tag_shift >= SHIFT_W'(ADDR_W)) ? '0 : (addr_q >> tag_shift);
		off_shifted = addr_q >> off_bits_q;
		set_mask    = ~({SET_W{1'b1}} << s_eff);
		set_calc    = off_shifted[SET_W-1:0] & set_mask;
	end

	always_comb begin
		if (ways_q == '0) begin
			last_way = '0;
		end else if (ways_q > WAYS_MAX) begin
			last_way = WAY_W'(MAX_WAYS - 1);
		end else begin
			last_way = WAY_W'(ways_q - 1'b1);
		end
	end

	assign line_hit   = row_rd.valid[way_q] && tag_match;
	assign vict_way   = (policy_q == POL_PLRU && !vict_found_q) ? last_way : vict_q;
	assign acc_way    = hit_q ? hit_way_q : vict_way;
	assign miss_evict = !hit_q && row_rd.valid[vict_way];
	assign slot_free  = !out_valid_q || !out_stall;

	assign repl_ctrl.way    = acc_way;
	assign repl_ctrl.last   = last_way;
	assign repl_ctrl.policy = policy_q;
	assign repl_ctrl.fill   = !hit_q;

	sacl_tag_store u_tags (
		.clk     (clk),
		.rd_en   (look_rd_en),
		.rd_addr ({set_q, way_q}),
		.cmp_tag (tag_q),
		.match   (tag_match),
		.wr_en   (tag_wr_en),
		.wr_addr ({set_q, acc_way}),
		.wr_tag  (tag_q)
	);

	sacl_meta_store u_meta (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (look_rd_en),
		.rd_set (set_q),
		.rd_row (row_rd),
		.wr_en  (commit),
		.wr_set (set_q),
		.wr_row (row_new),
		.busy   (meta_busy)
	);

	sacl_repl_update u_repl (
		.row_in  (row_rd),
		.ctrl    (repl_ctrl),
		.row_out (row_new)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (!meta_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (line_hit || way_q == last_way) state_d = ST_UPDATE;
				else state_d = ST_LOOK;
			end
			ST_UPDATE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		look_rd_en = (state_q == ST_LOOK);
		commit     = (state_q == ST_UPDATE) && slot_free;
		tag_wr_en  = commit && !hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			set_bits_q  <= RST_SET_BITS;
			off_bits_q  <= RST_OFF_BITS;
			ways_q      <= RST_WAYS;
			policy_q    <= POL_LRU;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (hit_q) begin
					if (hit_cnt_q != CNT_MAX) hit_cnt_q <= hit_cnt_q + 1'b1;
				end else begin
					if (miss_cnt_q != CNT_MAX) miss_cnt_q <= miss_cnt_q + 1'b1;
					if (miss_evict && evict_cnt_q != CNT_MAX) begin
						evict_cnt_q <= evict_cnt_q + 1'b1;
					end
				end
			end
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_SET_BITS:    set_bits_q <= cfg_data[SETB_W-1:0];
					CFG_OFFSET_BITS: off_bits_q <= cfg_data[OFFB_W-1:0];
					CFG_WAYS:        ways_q     <= cfg_data[WAYSCFG_W-1:0];
					CFG_POLICY:      policy_q   <= policy_t'(cfg_data[0]);
				endcase
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			addr_q <= access_address;
		end
		if (state_q == ST_PREP) begin
			set_q        <= set_calc;
			tag_q        <= tag_calc;
			way_q        <= '0;
			hit_q        <= 1'b0;
			vict_q       <= '0;
			vict_found_q <= 1'b0;
		end
		if (state_q == ST_CMP) begin
			if (line_hit) begin
				hit_q     <= 1'b1;
				hit_way_q <= way_q;
			end else begin
				if (policy_q == POL_PLRU) begin
					// ascending scan: last clear bit seen is the highest index
					if (!row_rd.recent[way_q]) begin
						vict_q       <= way_q;
						vict_found_q <= 1'b1;
					end
				end else if (!vict_found_q) begin
					if (!row_rd.valid[way_q]) begin
						vict_q       <= way_q;
						vict_found_q <= 1'b1;
					end else if (way_q == '0 || row_rd.rank[way_q] > row_rd.rank[vict_q]) begin
						vict_q <= way_q;
					end
				end
				if (way_q != last_way) begin
					way_q <= way_q + 1'b1;
				end
			end
		end
		if (commit) begin
			was_hit_q <= hit_q;
			evict_q   <= miss_evict;
		end
	end

	assign out_valid       = out_valid_q;
	assign was_hit         = was_hit_q;
	assign caused_eviction = evict_q;
	assign hit_total       = hit_cnt_q;
	assign miss_total      = miss_cnt_q;
	assign eviction_total  = evict_cnt_q;
	assign cfg_ready       = 1'b1;

	`SACL_ASSERT_NEVER(a_no_hit_evict, out_valid && was_hit && caused_eviction)
	`SACL_ASSERT(a_tag_wr_miss, tag_wr_en |-> (state_q == ST_UPDATE) && !hit_q)
	`SACL_ASSERT(a_clear_holds, meta_busy |-> state_q == ST_CLEAR)
	`SACL_ASSERT(a_scan_range, (state_q == ST_CMP) |-> (way_q <= last_way))

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for set_assoc_cache_lookup_lru_plru: a directed table, then random phases.
// Depends on sacl_pkg and the block's RTL; lookups are checked by a cache model or table values.
module tb_top;
	import sacl_pkg::*;

	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 132;
	localparam int QUIET_PHASES   = 2;
	localparam int PRESSURE_PHASE = 5;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 24;     // covers the worst lookup, a scan of every way
	localparam int LIMIT_CYCLES   = 600000;

	typedef struct packed {
		logic             hit;
		logic             evict;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] evicts;
	} lookup_result_t;

	typedef struct packed {
		bit                    is_cfg;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic [ADDR_W-1:0]     addr;
		bit                    typed;
		lookup_result_t        res;
	} step_row_t;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [ADDR_W-1:0]     access_address  = '0;
	logic                  out_valid;
	logic                  out_stall       = 1'b0;
	logic                  was_hit;
	logic                  caused_eviction;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;
	logic [CNT_W-1:0]      eviction_total;
	logic                  cfg_valid       = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index       = '0;
	logic [CFG_DATA_W-1:0] cfg_data        = '0;

	set_assoc_cache_lookup_lru_plru i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.access_address  (access_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.was_hit         (was_hit),
		.caused_eviction (caused_eviction),
		.hit_total       (hit_total),
		.miss_total      (miss_total),
		.eviction_total  (eviction_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// cache model state
	logic [ADDR_W-1:0] tag_mem    [NUM_SETS][MAX_WAYS];
	logic              valid_mem  [NUM_SETS][MAX_WAYS];
	logic [RANK_W-1:0] rank_mem   [NUM_SETS][MAX_WAYS];
	logic              recent_mem [NUM_SETS][MAX_WAYS];
	logic [CNT_W-1:0]  hits_seen, misses_seen, evicts_seen;
	logic [SETB_W-1:0]    model_set_bits;
	logic [OFFB_W-1:0]    model_off_bits;
	logic [WAYSCFG_W-1:0] model_ways;
	policy_t              model_policy;

	lookup_result_t pending_results[$];
	bit             idle_on      = 1'b1;
	bit             hold_request = 1'b0;
	int unsigned    mismatches   = 0;
	int unsigned    results_checked = 0;
	int unsigned    cycle_count  = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned live_set_bits();
		return (model_set_bits > SETB_MAX) ? MAX_SET_BITS : int'(model_set_bits);
	endfunction

	function automatic int unsigned live_ways();
		if (model_ways == 0)
			return 1;
		return (model_ways > WAYS_MAX) ? MAX_WAYS : int'(model_ways);
	endfunction

	function automatic void age_touch(int unsigned set_i, int unsigned w, int unsigned e);
		logic [RANK_W-1:0] old;
		old = rank_mem[set_i][w];
		for (int unsigned i = 0; i < e; i++)
			if (i != w && rank_mem[set_i][i] <= old && rank_mem[set_i][i] < RANK_MAX)
				rank_mem[set_i][i] = rank_mem[set_i][i] + 1'b1;
		rank_mem[set_i][w] = '0;
	endfunction

	function automatic void recent_touch(int unsigned set_i, int unsigned w, int unsigned e);
		int unsigned clear_cnt;
		clear_cnt = 0;
		for (int unsigned i = 0; i < e; i++)
			if (!recent_mem[set_i][i])
				clear_cnt++;
		if (clear_cnt <= 1)
			for (int unsigned i = 0; i < e; i++)
				recent_mem[set_i][i] = 1'b0;
		recent_mem[set_i][w] = 1'b1;
	endfunction

	function automatic lookup_result_t lookup_and_update(logic [ADDR_W-1:0] a);
		int unsigned s, b, e, set_i, way;
		logic [ADDR_W-1:0] tag;
		lookup_result_t r;
		s = live_set_bits();
		b = 32'(model_off_bits);
		e = live_ways();
		tag = (b + s >= ADDR_W) ? '0 : a >> (b + s);
		set_i = 32'((a >> b) & ((64'd1 << s) - 1));
		r = '0;
		way = e;
		for (int unsigned i = 0; i < e; i++)
			if (way == e && valid_mem[set_i][i] && tag_mem[set_i][i] == tag)
				way = i;
		if (way < e) begin
			r.hit = 1'b1;
			if (hits_seen != CNT_MAX)
				hits_seen++;
		end else begin
			if (misses_seen != CNT_MAX)
				misses_seen++;
			if (model_policy == POL_PLRU) begin
				way = e - 1;   // no clear bit: top way in use
				for (int unsigned i = 0; i < e; i++)
					if (!recent_mem[set_i][i])
						way = i;
			end else begin
				for (int unsigned i = 0; i < e; i++)
					if (way == e && !valid_mem[set_i][i])
						way = i;
				if (way == e) begin
					way = 0;
					for (int unsigned i = 1; i < e; i++)
						if (rank_mem[set_i][i] > rank_mem[set_i][way])
							way = i;
				end
			end
			if (valid_mem[set_i][way]) begin
				r.evict = 1'b1;
				if (evicts_seen != CNT_MAX)
					evicts_seen++;
			end
			tag_mem[set_i][way] = tag;
			valid_mem[set_i][way] = 1'b1;
		end
		if (model_policy == POL_PLRU)
			recent_touch(set_i, way, e);
		else
			age_touch(set_i, way, e);
		r.hits = hits_seen;
		r.misses = misses_seen;
		r.evicts = evicts_seen;
		return r;
	endfunction

	function automatic step_row_t reg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	function automatic step_row_t access_row(logic [ADDR_W-1:0] a);
		step_row_t r;
		r = '0;
		r.addr = a;
		return r;
	endfunction

	function automatic step_row_t known_row(logic [ADDR_W-1:0] a, logic h, logic ev,
			int unsigned ht, int unsigned mt, int unsigned et);
		step_row_t r;
		r = '0;
		r.addr = a;
		r.typed = 1'b1;
		r.res = '{h, ev, CNT_W'(ht), CNT_W'(mt), CNT_W'(et)};
		return r;
	endfunction

	// cfg_valid stays up across back-to-back writes, dropped after the last one
	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
			CFG_SET_BITS:    model_set_bits = val[SETB_W-1:0];
			CFG_OFFSET_BITS: model_off_bits = val[OFFB_W-1:0];
			CFG_WAYS:        model_ways     = val[WAYSCFG_W-1:0];
			CFG_POLICY:      model_policy   = policy_t'(val[0]);
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	// unused upper data bits carry noise; the block must ignore them
	task automatic write_config(logic [SETB_W-1:0] s, logic [OFFB_W-1:0] b,
			logic [WAYSCFG_W-1:0] e, policy_t p);
		write_reg(CFG_SET_BITS, {3'($urandom), s}, 1'b0);
		write_reg(CFG_OFFSET_BITS, b, 1'b0);
		write_reg(CFG_WAYS, {2'($urandom), e}, 1'b0);
		write_reg(CFG_POLICY, {5'($urandom), p}, 1'b1);
	endtask

	task automatic send_access(logic [ADDR_W-1:0] a, bit typed, lookup_result_t known);
		lookup_result_t predicted;
		in_valid       <= 1'b1;
		access_address <= a;
		do @(posedge clk); while (in_stall);
		predicted = lookup_and_update(a);
		pending_results.push_back(typed ? known : predicted);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// block idle: all results back, then the lookup latency
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// result checker
	initial begin
		lookup_result_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{was_hit, caused_eviction, hit_total, miss_total, eviction_total};
				results_checked++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: hit %0b evict %0b totals h%0d m%0d e%0d",
							got.hit, got.evict, got.hits, got.misses, got.evicts);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"lookup %0d: expected hit %0b evict %0b h%0d m%0d e%0d,",
								" got hit %0b evict %0b h%0d m%0d e%0d"}, results_checked,
								want.hit, want.evict, want.hits, want.misses, want.evicts,
								got.hit, got.evict, got.hits, got.misses, got.evicts);
					end
				end
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		step_row_t         directed_rows[$];
		logic [ADDR_W-1:0] tag_pool [16];
		int unsigned       set_pool [4];
		logic [ADDR_W-1:0] a;
		int unsigned       s, b, tag_span, last_cfg;

		foreach (tag_mem[i, j]) begin
			tag_mem[i][j]    = '0;
			valid_mem[i][j]  = 1'b0;
			rank_mem[i][j]   = '0;
			recent_mem[i][j] = 1'b0;
		end
		hits_seen      = '0;
		misses_seen    = '0;
		evicts_seen    = '0;
		model_set_bits = RST_SET_BITS;
		model_off_bits = RST_OFF_BITS;
		model_ways     = RST_WAYS;
		model_policy   = POL_LRU;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: 64 sets, 64-byte lines, 4 ways, true LRU
		directed_rows = '{
			known_row(64'h0, 1'b0, 1'b0, 0, 1, 0),
			known_row('1, 1'b0, 1'b0, 0, 2, 0),
			known_row(64'h0, 1'b1, 1'b0, 1, 2, 0),
			known_row(64'h1000, 1'b0, 1'b0, 1, 3, 0),
			known_row(64'h2000, 1'b0, 1'b0, 1, 4, 0),
			known_row(64'h3000, 1'b0, 1'b0, 1, 5, 0),
			known_row(64'h4000, 1'b0, 1'b1, 1, 6, 1),  // set 0 full: oldest goes
			access_row(64'h0),
			access_row(64'h1000),
			// bit-PLRU with zero ways (one way, bit always set)
			reg_row(CFG_POLICY, 6'd1),
			reg_row(CFG_WAYS, 6'd0),
			access_row(64'h5000),
			access_row(64'h5000),
			// ways above the maximum, set bits above the maximum, top offset
			reg_row(CFG_WAYS, 6'd15),
			reg_row(CFG_SET_BITS, 6'd7),
			reg_row(CFG_OFFSET_BITS, 6'd63),
			access_row(64'h8000_0000_0000_0000),
			access_row(64'h7FFF_FFFF_FFFF_FFFF),
			access_row('1),
			// offset plus set bits reach 64: tag is zero
			reg_row(CFG_OFFSET_BITS, 6'd58),
			reg_row(CFG_WAYS, 6'd8),
			access_row(64'hA5A5_5A5A_0F0F_F0F0),
			access_row(64'h5A5A_A5A5_F0F0_0F0F),
			// one set, whole address is the tag
			reg_row(CFG_SET_BITS, 6'd0),
			reg_row(CFG_OFFSET_BITS, 6'd0),
			reg_row(CFG_POLICY, 6'd0),
			access_row(64'h0),
			access_row(64'h1),
			access_row(64'h0),
			access_row('1)
		};

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg) begin
				if (k > 0 && !directed_rows[k-1].is_cfg)
					settle();
				last_cfg = 32'((k + 1 == directed_rows.size()) || !directed_rows[k+1].is_cfg);
				write_reg(directed_rows[k].idx, directed_rows[k].data, last_cfg != 0);
			end else begin
				send_access(directed_rows[k].addr, directed_rows[k].typed,
					directed_rows[k].res);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: write_config(3'd0, 6'd0, 4'd1, POL_LRU);
				1: write_config(3'd7, 6'd63, 4'd15, POL_PLRU);
				2: write_config(3'd6, 6'd32, 4'd8, POL_LRU);
				3: write_config(3'd3, 6'd4, 4'd0, POL_PLRU);
				default: write_config(3'($urandom_range(0, 7)),
					($urandom_range(0, 4) == 0) ? 6'($urandom_range(13, 63))
						: 6'($urandom_range(0, 12)),
					4'($urandom_range(0, 15)), policy_t'($urandom_range(0, 1)));
			endcase
			idle_on = (phase < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
			if (phase == PRESSURE_PHASE)
				hold_request = 1'b1;

			// small working set per phase so lines get hit, aged and evicted
			foreach (tag_pool[j])
				tag_pool[j] = (j < 8) ? ADDR_W'(j) : {$urandom, $urandom};
			foreach (set_pool[j])
				set_pool[j] = $urandom_range(0, NUM_SETS - 1);
			tag_span = live_ways() + $urandom_range(1, 4);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					a = {$urandom, $urandom};
				end else begin
					s = live_set_bits();
					b = 32'(model_off_bits);
					a = {$urandom, $urandom} & ((64'd1 << b) - 1);
					a |= (ADDR_W'(set_pool[$urandom_range(0, 3)]) & ((64'd1 << s) - 1)) << b;
					if (b + s < ADDR_W)
						a |= tag_pool[$urandom_range(0, tag_span - 1)] << (b + s);
				end
				send_access(a, 1'b0, '0);
			end
		end

		settle();
		$display("checked %0d lookups (%0d hits, %0d misses, %0d evictions) over %0d settings,",
			results_checked, hits_seen, misses_seen, evicts_seen, PHASES + 5);
		$display("both policies, odd way counts, wide shifts and a long output hold; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
